/* hdl/mprt_pkg.sv */
// Shared constants, types and tables for the pinch and rotate tracker.
`default_nettype none
package mprt_pkg;
  localparam int MaxTouches = 10;
  localparam int SlotW = $clog2(MaxTouches);

  localparam logic [1:0] KIND_BEGIN = 2'd0;
  localparam logic [1:0] KIND_UPDATE = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic signed [23:0] HALF_PI_Z = 24'sd1647099;
  localparam logic signed [15:0] ANGLE_MAX = 16'sd12868;

  // Datapath commands issued by the controller.
  typedef struct packed {
    logic load_in;      // latch input beat
    logic lookup;       // resolve id, update or claim slot
    logic free_slot;    // end event
    logic pair_setup;   // latch pair differences
    logic sq_x;         // dx*dx
    logic sq_y;         // dy*dy
    logic sqrt_init;
    logic sqrt_step;
    logic cordic_init;
    logic cordic_step;
    logic div_init;
    logic div_step;
    logic save_ref;
    logic emit_pan;
    logic emit_pinch;
  } mprt_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       slot_ok;     // found or claimed a slot
    logic [3:0] count;
    logic       pair_ok;
    logic       pan_ok;
    logic       small_ref;
  } mprt_sts_t;

  function automatic logic [23:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0: atan_lut = 24'd823550;
      5'd1: atan_lut = 24'd486170;
      5'd2: atan_lut = 24'd256879;
      5'd3: atan_lut = 24'd130396;
      5'd4: atan_lut = 24'd65451;
      5'd5: atan_lut = 24'd32757;
      5'd6: atan_lut = 24'd16383;
      5'd7: atan_lut = 24'd8192;
      5'd8: atan_lut = 24'd4096;
      5'd9: atan_lut = 24'd2048;
      5'd10: atan_lut = 24'd1024;
      5'd11: atan_lut = 24'd512;
      5'd12: atan_lut = 24'd256;
      5'd13: atan_lut = 24'd128;
      5'd14: atan_lut = 24'd64;
      5'd15: atan_lut = 24'd32;
      5'd16: atan_lut = 24'd16;
      5'd17: atan_lut = 24'd8;
      5'd18: atan_lut = 24'd4;
      5'd19: atan_lut = 24'd2;
      default: atan_lut = 24'd0;
    endcase
  endfunction
endpackage
`default_nettype wire

/* hdl/mprt_ctrl.sv */
// Controller state machine sequencing one touch event through the datapath.
`default_nettype none
module mprt_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  input  wire mprt_pkg::mprt_sts_t sts,
  output mprt_pkg::mprt_cmd_t      cmd
);
  import mprt_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOOK = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_SQX = 4'd3;
  localparam logic [3:0] S_SQY = 4'd4;
  localparam logic [3:0] S_INIT = 4'd5;
  localparam logic [3:0] S_ITER = 4'd6;
  localparam logic [3:0] S_DINIT = 4'd7;
  localparam logic [3:0] S_DIV = 4'd8;
  localparam logic [3:0] S_FIN = 4'd9;
  localparam logic [3:0] S_SETUP = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [5:0] step_r, step_nxt;
  logic       pinch_r, pinch_nxt;   // update (result) versus begin (refs only)
  logic       out_valid_r, out_valid_nxt;

  assign in_stall = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    pinch_nxt = pinch_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !out_valid_r) begin
          cmd.load_in = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (sts.kind == KIND_END) begin
          cmd.free_slot = 1'b1;
          state_nxt = S_IDLE;
        end else if (sts.kind == KIND_UNUSED) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.lookup = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_IDLE;
        if (sts.slot_ok) begin
          if (sts.count == 4'd2 && sts.pair_ok) begin
            cmd.pair_setup = 1'b1;
            pinch_nxt = (sts.kind == KIND_UPDATE);
            state_nxt = S_SETUP;
          end else if (sts.kind == KIND_UPDATE && sts.count == 4'd1 && sts.pan_ok) begin
            cmd.emit_pan = 1'b1;
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_SETUP: begin
        cmd.sq_x = 1'b1;
        state_nxt = S_SQX;
      end
      S_SQX: begin
        cmd.sq_y = 1'b1;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        cmd.sqrt_init = 1'b1;
        cmd.cordic_init = 1'b1;
        step_nxt = '0;
        state_nxt = S_ITER;
      end
      S_ITER: begin
        cmd.sqrt_step = 1'b1;
        if (step_r < 6'd20) cmd.cordic_step = 1'b1;
        step_nxt = step_r + 6'd1;
        if (step_r == 6'd24) state_nxt = S_INIT;
      end
      S_INIT: begin
        if (pinch_r) begin
          cmd.div_init = 1'b1;
          step_nxt = '0;
          state_nxt = S_DIV;
        end else begin
          cmd.save_ref = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt = step_r + 6'd1;
        if (step_r == 6'd40) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.emit_pinch = 1'b1;
        cmd.save_ref = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_DINIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r <= '0;
      pinch_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      pinch_r <= pinch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule
`default_nettype wire

/* hdl/mprt_dp.sv */
// Datapath: slot table, references, squarer, square root, CORDIC and divider.
`default_nettype none
module mprt_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mprt_pkg::mprt_cmd_t cmd,
  output mprt_pkg::mprt_sts_t      sts,
  input  wire logic [1:0]          in_event_kind,
  input  wire logic [31:0]         in_touch_id,
  input  wire logic signed [23:0]  in_x_position,
  input  wire logic signed [23:0]  in_y_position,
  output logic                     out_gesture_kind,
  output logic signed [23:0]       out_pan_x,
  output logic signed [23:0]       out_pan_y,
  output logic [23:0]              out_scale_ratio,
  output logic signed [15:0]       out_angle_change,
  output logic signed [24:0]       out_center_dx,
  output logic signed [24:0]       out_center_dy
);
  import mprt_pkg::*;

  logic [31:0]        slot_id_r [MaxTouches];
  logic [MaxTouches-1:0] slot_act_r;
  logic signed [23:0] slot_x_r [MaxTouches];
  logic signed [23:0] slot_y_r [MaxTouches];
  logic [3:0]         count_r;
  logic signed [23:0] ref_cx_r, ref_cy_r;
  logic [24:0]        ref_len_r;
  logic signed [15:0] ref_ang_r;

  logic [1:0]         kind_r;
  logic [31:0]        id_r;
  logic signed [23:0] px_r, py_r;
  logic               slot_ok_r;

  // Id match, first free slot, and first and last active slots.
  logic               found;
  logic [SlotW-1:0]   found_idx;
  logic               has_free;
  logic [SlotW-1:0]   free_idx;
  logic               pa_ok, pb_ok;
  logic [SlotW-1:0]   pa_idx, pb_idx;

  // Pair measurement.
  logic signed [24:0] dx_r, dy_r, cx_r, cy_r;
  logic [49:0]        sqx_r, sqy_r;
  logic [24:0]        dx_abs, dy_abs, sq_op;
  logic [49:0]        sq_prod;

  // CORDIC vectoring, one iteration per step.
  logic signed [35:0] cx_c_r, cy_c_r;
  logic signed [23:0] z_r;
  logic [4:0]         it_r;
  logic signed [35:0] x0, y0, sx, sy;
  logic signed [35:0] dx8, dy8;
  logic signed [23:0] z0;
  logic signed [23:0] zr;
  logic signed [15:0] ang;

  always_comb begin
    found = 1'b0;
    found_idx = '0;
    has_free = 1'b0;
    free_idx = '0;
    pa_ok = 1'b0;
    pb_ok = 1'b0;
    pa_idx = '0;
    pb_idx = '0;
    for (int i = 0; i < MaxTouches; i++) begin
      if (!found && slot_act_r[i] && slot_id_r[i] == id_r) begin
        found = 1'b1;
        found_idx = SlotW'(i);
      end
      if (!has_free && !slot_act_r[i]) begin
        has_free = 1'b1;
        free_idx = SlotW'(i);
      end
      if (slot_act_r[i]) begin
        if (!pa_ok) begin
          pa_ok = 1'b1;
          pa_idx = SlotW'(i);
        end else begin
          pb_ok = 1'b1;
          pb_idx = SlotW'(i);
        end
      end
    end
  end

  assign sts.kind = kind_r;
  assign sts.slot_ok = slot_ok_r;
  assign sts.count = count_r;
  assign sts.pair_ok = pa_ok && pb_ok;
  assign sts.pan_ok = pa_ok;
  assign sts.small_ref = (ref_len_r <= 25'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_act_r <= '0;
      count_r <= '0;
      ref_cx_r <= '0;
      ref_cy_r <= '0;
      ref_len_r <= '0;
      ref_ang_r <= '0;
      kind_r <= '0;
      slot_ok_r <= 1'b0;
      for (int i = 0; i < MaxTouches; i++) begin
        slot_id_r[i] <= '0;
        slot_x_r[i] <= '0;
        slot_y_r[i] <= '0;
      end
    end else begin
      if (cmd.load_in) begin
        kind_r <= in_event_kind;
        id_r <= in_touch_id;
        px_r <= in_x_position;
        py_r <= in_y_position;
      end
      if (cmd.free_slot) begin
        if (found) begin
          slot_act_r[found_idx] <= 1'b0;
          slot_id_r[found_idx] <= '0;
        end
        if (count_r != 4'd0) count_r <= count_r - 4'd1;
      end
      if (cmd.lookup) begin
        slot_ok_r <= found || has_free;
        if (found) begin
          slot_x_r[found_idx] <= px_r;
          slot_y_r[found_idx] <= py_r;
        end else if (has_free) begin
          slot_id_r[free_idx] <= id_r;
          slot_act_r[free_idx] <= 1'b1;
          slot_x_r[free_idx] <= px_r;
          slot_y_r[free_idx] <= py_r;
          if (count_r != 4'd15) count_r <= count_r + 4'd1;
        end
      end
      if (cmd.save_ref) begin
        ref_cx_r <= cx_r[23:0];
        ref_cy_r <= cy_r[23:0];
        ref_len_r <= root_r;
        ref_ang_r <= ang;
      end
    end
  end

  assign dx_abs = dx_r[24] ? 25'(-dx_r) : dx_r;
  assign dy_abs = dy_r[24] ? 25'(-dy_r) : dy_r;
  assign sq_op = cmd.sq_x ? dx_abs : dy_abs;
  assign sq_prod = 50'(sq_op) * 50'(sq_op);

  always_ff @(posedge clk) begin
    if (cmd.pair_setup) begin
      dx_r <= 25'(slot_x_r[pb_idx]) - 25'(slot_x_r[pa_idx]);
      dy_r <= 25'(slot_y_r[pb_idx]) - 25'(slot_y_r[pa_idx]);
      cx_r <= (25'(slot_x_r[pa_idx]) + 25'(slot_x_r[pb_idx])) >>> 1;
      cy_r <= (25'(slot_y_r[pa_idx]) + 25'(slot_y_r[pb_idx])) >>> 1;
    end
    if (cmd.sq_x) sqx_r <= sq_prod;
    if (cmd.sq_y) sqy_r <= sq_prod;
  end

  // Integer square root, one result bit per step (25 steps over 50 bits).
  logic [51:0] rem_r;
  logic [49:0] val_r;
  logic [24:0] root_r;
  logic [51:0] rem_try;
  logic [51:0] trial;

  assign rem_try = {rem_r[49:0], val_r[49:48]};
  assign trial = {25'd0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      rem_r <= '0;
      root_r <= '0;
      val_r <= sqx_r + sqy_r;
    end else if (cmd.sqrt_step) begin
      val_r <= {val_r[47:0], 2'b00};
      if (rem_try >= trial) begin
        rem_r <= rem_try - trial;
        root_r <= {root_r[23:0], 1'b1};
      end else begin
        rem_r <= rem_try;
        root_r <= {root_r[23:0], 1'b0};
      end
    end
  end

  // Differences scaled by 256 with the sign carried into the upper bits.
  assign dx8 = {{3{dx_r[24]}}, dx_r, 8'd0};
  assign dy8 = {{3{dy_r[24]}}, dy_r, 8'd0};

  always_comb begin
    x0 = dx8;
    y0 = dy8;
    z0 = '0;
    if (x0 < 0) begin
      if (y0 >= 0) begin
        x0 = dy8;
        y0 = -dx8;
        z0 = HALF_PI_Z;
      end else begin
        x0 = -dy8;
        y0 = dx8;
        z0 = -HALF_PI_Z;
      end
    end
    sx = cx_c_r >>> it_r;
    sy = cy_c_r >>> it_r;
    zr = (z_r + 24'sd128) >>> 8;
    if (zr > 24'(ANGLE_MAX)) ang = ANGLE_MAX;
    else if (zr < -24'(ANGLE_MAX)) ang = -ANGLE_MAX;
    else ang = zr[15:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.cordic_init) begin
      cx_c_r <= x0;
      cy_c_r <= y0;
      z_r <= z0;
      it_r <= '0;
    end else if (cmd.cordic_step) begin
      it_r <= it_r + 5'd1;
      if (cy_c_r > 0) begin
        cx_c_r <= cx_c_r + sy;
        cy_c_r <= cy_c_r - sx;
        z_r <= z_r + $signed(atan_lut(it_r));
      end else if (cy_c_r < 0) begin
        cx_c_r <= cx_c_r - sy;
        cy_c_r <= cy_c_r + sx;
        z_r <= z_r - $signed(atan_lut(it_r));
      end
    end
  end

  // Restoring divider: (dist << 16) / reference distance, 41 quotient bits.
  logic [40:0] num_r, quo_r;
  logic [25:0] drem_r;
  logic [25:0] drem_sh;

  assign drem_sh = {drem_r[24:0], num_r[40]};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      num_r <= {root_r, 16'd0};
      quo_r <= '0;
      drem_r <= '0;
    end else if (cmd.div_step) begin
      num_r <= {num_r[39:0], 1'b0};
      if (drem_sh >= {1'b0, ref_len_r}) begin
        drem_r <= drem_sh - {1'b0, ref_len_r};
        quo_r <= {quo_r[39:0], 1'b1};
      end else begin
        drem_r <= drem_sh;
        quo_r <= {quo_r[39:0], 1'b0};
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.emit_pan) begin
      out_gesture_kind <= 1'b0;
      out_pan_x <= slot_x_r[pa_idx];
      out_pan_y <= slot_y_r[pa_idx];
      out_scale_ratio <= '0;
      out_angle_change <= '0;
      out_center_dx <= '0;
      out_center_dy <= '0;
    end
    if (cmd.emit_pinch) begin
      out_gesture_kind <= 1'b1;
      out_pan_x <= '0;
      out_pan_y <= '0;
      if (sts.small_ref) out_scale_ratio <= 24'd65536;
      else if (quo_r[40:24] != '0) out_scale_ratio <= 24'hFFFFFF;
      else out_scale_ratio <= quo_r[23:0];
      out_angle_change <= ang - ref_ang_r;
      out_center_dx <= cx_r - 25'(ref_cx_r);
      out_center_dy <= cy_r - 25'(ref_cy_r);
    end
  end
endmodule
`default_nettype wire

/* hdl/multitouch_pinch_rotate_tracker.sv */
// Timing: a pan result is registered in the decide state after its beat's lookup; a pinch
// result follows the 25-step square root and the 41-step divider.
// Flow: one event at a time; a new beat is stalled until the controller is idle and any
// pending result has been taken.
// Reset: synchronous active-low rst_n frees all slots and clears references.
`default_nettype none
module multitouch_pinch_rotate_tracker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_event_kind,
  input  wire logic [31:0]        in_touch_id,
  input  wire logic signed [23:0] in_x_position,
  input  wire logic signed [23:0] in_y_position,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_gesture_kind,
  output logic signed [23:0]      out_pan_x,
  output logic signed [23:0]      out_pan_y,
  output logic [23:0]             out_scale_ratio,
  output logic signed [15:0]      out_angle_change,
  output logic signed [24:0]      out_center_dx,
  output logic signed [24:0]      out_center_dy
);
  import mprt_pkg::*;

  mprt_cmd_t cmd;
  mprt_sts_t sts;

  mprt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  mprt_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_event_kind(in_event_kind), .in_touch_id(in_touch_id),
    .in_x_position(in_x_position), .in_y_position(in_y_position),
    .out_gesture_kind(out_gesture_kind), .out_pan_x(out_pan_x),
    .out_pan_y(out_pan_y), .out_scale_ratio(out_scale_ratio),
    .out_angle_change(out_angle_change), .out_center_dx(out_center_dx),
    .out_center_dy(out_center_dy)
  );
endmodule
`default_nettype wire
